// ----- sv/lfi_pkg.sv -----
// Package for the length-prefixed frame indexer.
// Holds the request and result item types and the code constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lfi_pkg;

  // Request type codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // Result kind codes.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // Final status codes.
  localparam logic [2:0] STATUS_VALID         = 3'd0;
  localparam logic [2:0] STATUS_BAD_COUNT     = 3'd1;
  localparam logic [2:0] STATUS_COUNT_OVER    = 3'd2;
  localparam logic [2:0] STATUS_PAYLOAD_OVER  = 3'd3;
  localparam logic [2:0] STATUS_TRUNCATED     = 3'd4;
  localparam logic [2:0] STATUS_ZERO_LENGTH   = 3'd5;
  localparam logic [2:0] STATUS_FRAME_OVER    = 3'd6;
  localparam logic [2:0] STATUS_TRAILING      = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TOTAL_BYTES      = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_FRAMES  = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME_LENGTH = 2'd2;

  // Size of a frame's length word in bytes.
  localparam logic [32:0] LENGTH_WORD_BYTES = 33'd4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] frame_index;
    logic [31:0] frame_offset;
    logic [31:0] frame_length;
    logic [2:0]  status;
  } rsp_item_t;

endpackage

`default_nettype wire

// ----- sv/lfi_in_reg.sv -----
// Input register of the frame indexer: holds one accepted request.
// Depends on lfi_pkg for the request item type.
`default_nettype none

module lfi_in_reg
  import lfi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req,
  input  wire logic      take,
  output logic           item_valid,
  output req_item_t      item
);

  logic full;
  logic accept;

  // A new request enters when the register is empty or drains this cycle.
  assign req_stall  = full && !take;
  assign accept     = req_valid && !req_stall;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lfi_core.sv -----
// Run state, configuration registers and per-byte checks of the frame indexer.
// Depends on lfi_pkg for item types, status codes and register indexes.
`default_nettype none

module lfi_core
  import lfi_pkg::*;
#(
  parameter logic [31:0] MAX_PAYLOAD_BYTES = 32'd16777216,
  parameter logic [15:0] MAX_FRAMES        = 16'd4096
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        step,
  input  wire req_item_t   item,
  output logic             res_valid,
  output rsp_item_t        res
);

  // Configuration registers.
  logic [31:0] total_bytes;
  logic [15:0] expected_frames;
  logic [31:0] max_frame_length;

  // Run state.
  logic        in_body;
  logic [31:0] length_accum;
  logic [1:0]  length_bytes_seen;
  logic [31:0] byte_offset;
  logic [31:0] body_remaining;
  logic [15:0] frames_done;
  logic        run_finished;

  logic        in_body_next;
  logic [31:0] length_accum_next;
  logic [1:0]  length_bytes_seen_next;
  logic [31:0] byte_offset_next;
  logic [31:0] body_remaining_next;
  logic [15:0] frames_done_next;
  logic        run_finished_next;

  logic [31:0] offset_inc;
  logic [31:0] accum_merged;
  logic [31:0] remaining_dec;
  logic [15:0] frames_inc;
  logic [32:0] frame_end;
  logic [32:0] word_end;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bytes      <= '0;
      expected_frames  <= 16'd1;
      max_frame_length <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_BYTES:      total_bytes      <= cfg_data;
        CFG_EXPECTED_FRAMES:  expected_frames  <= cfg_data[15:0];
        CFG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared arithmetic for one byte.
  always_comb begin
    offset_inc    = byte_offset + 32'd1;
    accum_merged  = length_accum | ({24'd0, item.data_byte} << {length_bytes_seen, 3'b000});
    remaining_dec = (body_remaining != 32'd0) ? body_remaining - 32'd1 : body_remaining;
    frames_inc    = frames_done + 16'd1;
    // The frame overruns the payload when offset plus length passes its size.
    frame_end     = {1'b0, offset_inc} + {1'b0, accum_merged};
    // The next length word fits when offset plus four stays within the size.
    word_end      = {1'b0, offset_inc} + LENGTH_WORD_BYTES;
  end

  // Next state and result for the request in the input register.
  always_comb begin
    in_body_next           = in_body;
    length_accum_next      = length_accum;
    length_bytes_seen_next = length_bytes_seen;
    byte_offset_next       = byte_offset;
    body_remaining_next    = body_remaining;
    frames_done_next       = frames_done;
    run_finished_next      = run_finished;
    res_valid              = 1'b0;
    res.result_kind        = KIND_FINAL;
    res.frame_index        = frames_done;
    res.frame_offset       = byte_offset;
    res.frame_length       = '0;
    res.status             = STATUS_VALID;

    if (item.req_type == REQ_START) begin
      // Start: clear the run, then the upfront checks in order.
      in_body_next           = 1'b0;
      length_accum_next      = '0;
      length_bytes_seen_next = '0;
      byte_offset_next       = '0;
      body_remaining_next    = '0;
      frames_done_next       = '0;
      run_finished_next      = 1'b1;
      res_valid              = 1'b1;
      res.frame_index        = '0;
      res.frame_offset       = '0;
      priority if (total_bytes > MAX_PAYLOAD_BYTES) begin
        res.status = STATUS_PAYLOAD_OVER;
      end else if (expected_frames == 16'd0) begin
        res.status = STATUS_BAD_COUNT;
      end else if (expected_frames > MAX_FRAMES) begin
        res.status = STATUS_COUNT_OVER;
      end else if (total_bytes < 32'd4) begin
        res.status = STATUS_TRUNCATED;
      end else begin
        run_finished_next = 1'b0;
        res_valid         = 1'b0;
      end
    end else if (!run_finished && !in_body) begin
      // Length word byte, least significant first.
      byte_offset_next  = offset_inc;
      length_accum_next = accum_merged;
      res.frame_offset  = offset_inc;
      if (length_bytes_seen != 2'd3) begin
        length_bytes_seen_next = length_bytes_seen + 2'd1;
      end else begin
        length_bytes_seen_next = '0;
        res_valid              = 1'b1;
        run_finished_next      = 1'b1;
        priority if (accum_merged == 32'd0) begin
          res.status = STATUS_ZERO_LENGTH;
        end else if (accum_merged > max_frame_length) begin
          res.status = STATUS_FRAME_OVER;
        end else if (frame_end > {1'b0, total_bytes}) begin
          res.status = STATUS_TRUNCATED;
        end else begin
          // Good length: emit the frame entry and enter the body.
          run_finished_next   = 1'b0;
          res.result_kind     = KIND_FRAME;
          res.frame_length    = accum_merged;
          body_remaining_next = accum_merged;
          length_accum_next   = '0;
          in_body_next        = 1'b1;
        end
      end
    end else if (!run_finished) begin
      // Body byte; the last one closes the frame.
      byte_offset_next    = offset_inc;
      body_remaining_next = remaining_dec;
      if (remaining_dec == 32'd0) begin
        in_body_next     = 1'b0;
        frames_done_next = frames_inc;
        res.frame_index  = frames_inc;
        res.frame_offset = offset_inc;
        if (frames_inc >= expected_frames) begin
          res_valid         = 1'b1;
          run_finished_next = 1'b1;
          res.status = (offset_inc != total_bytes) ? STATUS_TRAILING : STATUS_VALID;
        end else if (word_end > {1'b0, total_bytes}) begin
          res_valid         = 1'b1;
          run_finished_next = 1'b1;
          res.status        = STATUS_TRUNCATED;
        end
      end
    end
  end

  // State update, one request per cycle while step is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_body           <= 1'b0;
      length_accum      <= '0;
      length_bytes_seen <= '0;
      byte_offset       <= '0;
      body_remaining    <= '0;
      frames_done       <= '0;
      run_finished      <= 1'b1;
    end else if (step) begin
      in_body           <= in_body_next;
      length_accum      <= length_accum_next;
      length_bytes_seen <= length_bytes_seen_next;
      byte_offset       <= byte_offset_next;
      body_remaining    <= body_remaining_next;
      frames_done       <= frames_done_next;
      run_finished      <= run_finished_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lfi_out_reg.sv -----
// Result register of the frame indexer: holds one result until taken.
// Depends on lfi_pkg for the result item type.
`default_nettype none

module lfi_out_reg
  import lfi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire rsp_item_t result,
  output logic           ready,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp
);

  // Room for a new result when empty or when the held one leaves this cycle.
  assign ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ready) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

// ----- sv/length_prefixed_frame_indexer.sv -----
// Top level of the length-prefixed frame indexer.
// Depends on lfi_pkg, lfi_in_reg, lfi_core and lfi_out_reg.
//
//   Channel   Signals                         Carries
//   request   req_valid, req_stall, req       start or one payload byte
//   result    rsp_valid, rsp_stall, rsp       frame entry or final status
//   config    cfg_we, cfg_index, cfg_data     register writes, no read-back
//
// One request is taken every cycle while the result side does not stall; it is
// held in the input register and processed by lfi_core, and any result is then
// registered in the result register, from which it can leave.
// Synchronous reset clears the run state and loads the register defaults.
// A stall on the result side holds the result register and, through it,
// stalls the request side once the input register is full.
`default_nettype none

module length_prefixed_frame_indexer
  import lfi_pkg::*;
#(
  parameter logic [31:0] MAX_PAYLOAD_BYTES = 32'd16777216,
  parameter logic [15:0] MAX_FRAMES        = 16'd4096
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_item_t   req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_item_t        rsp,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic      item_valid;
  req_item_t item;
  logic      out_ready;
  logic      step;
  logic      res_valid;
  rsp_item_t res;

  // A held request is processed whenever the result register has room.
  assign step = item_valid && out_ready;

  lfi_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  lfi_core #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
    .MAX_FRAMES        (MAX_FRAMES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  lfi_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .result    (res),
    .ready     (out_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
